// File: hdl/sip_pkg.sv
package sip_pkg;

   localparam int VAL_W  = 64;
   localparam int BASE_W = 6;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_BASE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNSIGNED_MODE = 1'd1;

   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd63;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGN,
      PH_ZERO,
      PH_PREFIX,
      PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_RANGE,
      ST_BASE
   } status_type;

   typedef enum logic [3:0] {
      ACT_SKIP,
      ACT_SIGN,
      ACT_ZERO,
      ACT_PREFIX,
      ACT_DIGIT,
      ACT_FINISH,
      ACT_BADBASE,
      ACT_CLEAR
   } action_type;

   typedef struct packed {
      phase_type         phase;
      logic [BASE_W-1:0] eff_base;
      logic              minus;
      logic              ovf;
      logic              digits;
   } ctrl_type;

   localparam ctrl_type CTRL_CLEAR = '{phase: PH_SPACE, eff_base: BASE_AUTO,
                                       minus: 1'b0, ovf: 1'b0, digits: 1'b0};

   // 0-9, a-z, A-Z to digit value; anything else is DIGIT_NONE (above any base)
   function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
      logic [BASE_W-1:0] d;
      begin
         d = DIGIT_NONE;
         if (c >= CH_0 && c <= CH_9) begin
            d = BASE_W'(c - CH_0);
         end else if (c >= CH_LA && c <= CH_LZ) begin
            d = BASE_W'(c - CH_LA) + BASE_DEC;
         end else if (c >= CH_UA && c <= CH_UZ) begin
            d = BASE_W'(c - CH_UA) + BASE_DEC;
         end
         return d;
      end
   endfunction

endpackage

// File: hdl/sip_req_if.sv
interface sip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

// File: hdl/sip_rsp_if.sv
interface sip_rsp_if #(
   parameter int COUNT_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic signed [63:0]     value;
   logic [COUNT_BITS-1:0]  end_offset;
   logic                   number_found;
   logic [1:0]             status;

   modport source (output valid, output value, output end_offset, output number_found,
                   output status, input ready);
   modport sink   (input valid, input value, input end_offset, input number_found,
                   input status, output ready);
endinterface

// File: hdl/sip_step.sv
module sip_step import sip_pkg::*; #(
   parameter int RESULT_BITS = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic [7:0]              char_byte,
   input  logic [BASE_W-1:0]       number_base,
   input  logic                    unsigned_mode,
   input  ctrl_type                ctrl_cur,
   input  logic [RESULT_BITS-1:0]  acc_cur,
   input  logic [COUNT_BITS-1:0]   count_cur,
   output ctrl_type                ctrl_nxt,
   output logic [RESULT_BITS-1:0]  acc_nxt,
   output logic [COUNT_BITS-1:0]   count_nxt,
   output logic                    emit,
   output logic [VAL_W-1:0]        res_value,
   output logic [COUNT_BITS-1:0]   res_offset,
   output logic                    res_found,
   output status_type              res_status
);

   localparam int PROD_W = RESULT_BITS + 7;

   action_type              action;
   logic                    base_bad;
   logic                    is_space;
   logic                    is_sign;
   logic                    is_x;
   logic [BASE_W-1:0]       first_base;
   logic [BASE_W-1:0]       digit_base;
   logic                    first_zero;
   logic [BASE_W-1:0]       digit;
   logic                    digit_ok;
   logic [RESULT_BITS-1:0]  lim;
   logic [PROD_W-1:0]       prod;
   logic                    ovf_now;
   logic [COUNT_BITS-1:0]   count_up;
   logic [VAL_W-1:0]        acc_wide;
   logic [VAL_W-1:0]        mask_wide;
   logic [VAL_W-1:0]        min_wide;

   assign base_bad = (number_base == 6'd1) || (number_base > BASE_MAX);
   assign is_space = (char_byte inside {[CH_TAB:CH_CR], CH_SPACE});
   assign is_sign  = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
   assign is_x     = (char_byte == CH_LX) || (char_byte == CH_UX);

   // base is latched from the register on the first non-space character
   assign first_base = (ctrl_cur.phase == PH_SPACE) ? number_base : ctrl_cur.eff_base;
   assign first_zero = (char_byte == CH_0) &&
                       ((first_base == BASE_AUTO) || (first_base == BASE_HEX));

   always_comb begin
      case (ctrl_cur.phase)
         PH_SPACE, PH_SIGN: digit_base = (first_base == BASE_AUTO) ? BASE_DEC : first_base;
         PH_ZERO:           digit_base = (ctrl_cur.eff_base == BASE_AUTO) ? BASE_OCT
                                                                         : ctrl_cur.eff_base;
         default:           digit_base = ctrl_cur.eff_base;
      endcase
   end

   assign digit    = digit_of(char_byte);
   assign digit_ok = (digit_base >= 6'd2) && (digit < digit_base);

   always_comb begin
      if (unsigned_mode) begin
         lim = '1;
      end else if (ctrl_cur.minus) begin
         lim = {1'b1, {(RESULT_BITS-1){1'b0}}};
      end else begin
         lim = {1'b0, {(RESULT_BITS-1){1'b1}}};
      end
   end

   // acc*b + d > lim is the same test as acc > (lim - d) / b
   assign prod    = PROD_W'(acc_cur) * PROD_W'(digit_base) + PROD_W'(digit);
   assign ovf_now = prod > PROD_W'(lim);

   assign count_up = (count_cur == '1) ? count_cur : count_cur + 1'b1;

   always_comb begin
      case (ctrl_cur.phase)
         PH_SPACE: begin
            if (base_bad)        action = ACT_BADBASE;
            else if (is_space)   action = ACT_SKIP;
            else if (is_sign)    action = ACT_SIGN;
            else if (first_zero) action = ACT_ZERO;
            else if (digit_ok)   action = ACT_DIGIT;
            else                 action = ACT_FINISH;
         end
         PH_SIGN: begin
            if (first_zero)      action = ACT_ZERO;
            else if (digit_ok)   action = ACT_DIGIT;
            else                 action = ACT_FINISH;
         end
         PH_ZERO: begin
            if (is_x)            action = ACT_PREFIX;
            else if (digit_ok)   action = ACT_DIGIT;
            else                 action = ACT_FINISH;
         end
         PH_PREFIX, PH_DIGITS: begin
            action = digit_ok ? ACT_DIGIT : ACT_FINISH;
         end
         default: action = ACT_CLEAR;
      endcase
   end

   // next state
   always_comb begin
      ctrl_nxt  = ctrl_cur;
      acc_nxt   = acc_cur;
      count_nxt = count_cur;
      case (action)
         ACT_SKIP: begin
            count_nxt = count_up;
         end
         ACT_SIGN: begin
            ctrl_nxt.eff_base = number_base;
            ctrl_nxt.minus    = (char_byte == CH_MINUS);
            ctrl_nxt.phase    = PH_SIGN;
            count_nxt         = count_up;
         end
         ACT_ZERO: begin
            ctrl_nxt.eff_base = first_base;
            ctrl_nxt.digits   = 1'b1;
            ctrl_nxt.phase    = PH_ZERO;
            acc_nxt           = '0;
            count_nxt         = count_up;
         end
         ACT_PREFIX: begin
            ctrl_nxt.eff_base = BASE_HEX;
            ctrl_nxt.digits   = 1'b0;
            ctrl_nxt.phase    = PH_PREFIX;
            count_nxt         = count_up;
         end
         ACT_DIGIT: begin
            ctrl_nxt.eff_base = digit_base;
            ctrl_nxt.digits   = 1'b1;
            ctrl_nxt.phase    = PH_DIGITS;
            count_nxt         = count_up;
            if (!ctrl_cur.ovf) begin
               if (ovf_now) ctrl_nxt.ovf = 1'b1;
               else         acc_nxt = prod[RESULT_BITS-1:0];
            end
         end
         ACT_FINISH, ACT_BADBASE, ACT_CLEAR: begin
            ctrl_nxt  = CTRL_CLEAR;
            acc_nxt   = '0;
            count_nxt = '0;
         end
         default: begin
            ctrl_nxt  = CTRL_CLEAR;
            acc_nxt   = '0;
            count_nxt = '0;
         end
      endcase
   end

   assign acc_wide  = VAL_W'(acc_cur);
   assign mask_wide = VAL_W'({RESULT_BITS{1'b1}});
   assign min_wide  = VAL_W'(0) - (VAL_W'(1) << (RESULT_BITS - 1));

   // result word
   always_comb begin
      emit       = 1'b0;
      res_value  = '0;
      res_offset = '0;
      res_found  = 1'b0;
      res_status = ST_OK;
      case (action)
         ACT_FINISH: begin
            emit       = 1'b1;
            res_found  = ctrl_cur.digits;
            res_offset = ctrl_cur.digits ? count_cur : '0;
            if (ctrl_cur.ovf) begin
               res_status = ST_RANGE;
               if (unsigned_mode)       res_value = mask_wide;
               else if (ctrl_cur.minus) res_value = min_wide;
               else                     res_value = mask_wide >> 1;
            end else if (ctrl_cur.minus) begin
               res_value = unsigned_mode ? ((VAL_W'(0) - acc_wide) & mask_wide)
                                         : (VAL_W'(0) - acc_wide);
            end else begin
               res_value = acc_wide;
            end
         end
         ACT_BADBASE: begin
            emit       = 1'b1;
            res_status = ST_BASE;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/string_to_integer_parser.sv
// String-to-integer parser, strtol style, one character per word.
//
// req_chan carries one character per word; rsp_chan carries one result word
// when a character ends a number or finds number_base invalid (value, end_offset,
// number_found, status). Any other character produces no result word.
// csr_write_en/csr_index/csr_write_data write number_base (index 0) and
// unsigned_mode (index 1); write them only while the parser is idle.
//
// Throughput: one character per cycle while rsp_chan does not stall. The
// per-character multiply-add by the base with its range compare sits
// between the input register and the result register, so there is
// nothing else to wait on. A terminating character goes from the input
// register through that logic into the result register.
// When rsp_chan stalls, the result register holds; one more character may be
// taken into the input register, after which req_chan.ready drops.
// Reset (synchronous, active high) empties both registers, returns the parse
// to skipping white space and sets number_base to 10, unsigned_mode to 0.
module string_to_integer_parser import sip_pkg::*; #(
   parameter int RESULT_BITS = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BASE_W-1:0]      csr_write_data,
   sip_req_if.sink                req_chan,
   sip_rsp_if.source              rsp_chan
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff, in_char_in;
   logic [BASE_W-1:0]      number_base_ff, number_base_in;
   logic                   unsigned_mode_ff, unsigned_mode_in;
   ctrl_type               ctrl_ff, ctrl_in;
   logic [RESULT_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [COUNT_BITS-1:0]  rsp_offset_ff, rsp_offset_in;
   logic                   rsp_found_ff, rsp_found_in;
   status_type             rsp_status_ff, rsp_status_in;

   ctrl_type               step_ctrl;
   logic [RESULT_BITS-1:0] step_acc;
   logic [COUNT_BITS-1:0]  step_count;
   logic                   step_emit;
   logic [VAL_W-1:0]       step_value;
   logic [COUNT_BITS-1:0]  step_offset;
   logic                   step_found;
   status_type             step_status;
   logic                   advance;
   logic                   req_take;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready        = !in_valid_ff || advance;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.value        = rsp_value_ff;
   assign rsp_chan.end_offset   = rsp_offset_ff;
   assign rsp_chan.number_found = rsp_found_ff;
   assign rsp_chan.status       = rsp_status_ff;

   sip_step #(
      .RESULT_BITS (RESULT_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_step (
      .char_byte     (in_char_ff),
      .number_base   (number_base_ff),
      .unsigned_mode (unsigned_mode_ff),
      .ctrl_cur      (ctrl_ff),
      .acc_cur       (acc_ff),
      .count_cur     (count_ff),
      .ctrl_nxt      (step_ctrl),
      .acc_nxt       (step_acc),
      .count_nxt     (step_count),
      .emit          (step_emit),
      .res_value     (step_value),
      .res_offset    (step_offset),
      .res_found     (step_found),
      .res_status    (step_status)
   );

   always_comb begin
      number_base_in   = number_base_ff;
      unsigned_mode_in = unsigned_mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_NUMBER_BASE:   number_base_in   = csr_write_data;
            CSR_UNSIGNED_MODE: unsigned_mode_in = csr_write_data[0];
            default: begin
               number_base_in   = number_base_ff;
               unsigned_mode_in = unsigned_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_chan.char_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      ctrl_in       = ctrl_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      if (advance) begin
         ctrl_in  = step_ctrl;
         acc_in   = step_acc;
         count_in = step_count;
         if (step_emit) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = step_value;
            rsp_offset_in = step_offset;
            rsp_found_in  = step_found;
            rsp_status_in = step_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         number_base_ff   <= BASE_RESET;
         unsigned_mode_ff <= 1'b0;
         ctrl_ff          <= CTRL_CLEAR;
         acc_ff           <= '0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         number_base_ff   <= number_base_in;
         unsigned_mode_ff <= unsigned_mode_in;
         ctrl_ff          <= ctrl_in;
         acc_ff           <= acc_in;
         count_ff         <= count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff    <= in_char_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTH
   // a held character must not move while the result register is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("input register changed while stalled");

   a_no_number_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("offset given without a number");

   a_bad_base_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_BASE |-> rsp_value_ff == '0 && !rsp_found_ff)
      else $error("invalid-base word carries data");

   a_digit_base: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.phase == PH_DIGITS |-> ctrl_ff.eff_base >= 6'd2 && ctrl_ff.eff_base <= BASE_MAX)
      else $error("digit phase with unusable base");

   a_space_clean: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.phase == PH_SPACE |-> !ctrl_ff.digits && !ctrl_ff.ovf && acc_ff == '0)
      else $error("parse state not cleared between numbers");
`endif

endmodule
